// ----- hw/rtl/pim_pkg.sv -----
package pim_pkg;

  localparam int MAX_TASKS = 16;
  localparam int TASK_W    = 4;
  localparam int PRIO_W    = 8;
  localparam int STATUS_W  = 3;

  localparam logic [PRIO_W-1:0] PRIO_MAX = 8'hFF;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ACQUIRED  = 3'd0,
    STAT_QUEUED    = 3'd1,
    STAT_HANDOFF   = 3'd2,
    STAT_RELEASED  = 3'd3,
    STAT_NOT_OWNER = 3'd4,
    STAT_FULL      = 3'd5
  } status_t;

  typedef enum logic {
    OP_LOCK   = 1'b0,
    OP_UNLOCK = 1'b1
  } op_t;

endpackage

// ----- hw/rtl/pim_ram.sv -----
module pim_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hw/rtl/priority_inheritance_mutex.sv -----
// Channel   Ports                                       Transfer
// input     in_operation, in_task_id, in_task_priority  start && !busy
// result    out_status .. out_switch_request            out_valid, one cycle
//
// A lock, a rejected unlock or an unlock with nobody waiting yields its result
// in the cycle after the transaction is taken; busy stays low throughout.
// An unlock that hands off scans all n waiters in the queue RAM (one read per
// cycle), then shifts the entries behind the winner down one slot; busy is high
// through the scan and the shift, which share the single read port of the RAM.
// Reset clears the lock and empties the queue; no clearing pass is needed.
// The receiver cannot stall: each result is shown for exactly one cycle.
module priority_inheritance_mutex #(
  parameter int MAX_TASKS = pim_pkg::MAX_TASKS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_operation,
  input  logic [pim_pkg::TASK_W-1:0]    in_task_id,
  input  logic [pim_pkg::PRIO_W-1:0]    in_task_priority,
  output logic                          out_valid,
  output logic [pim_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_owner_valid,
  output logic [pim_pkg::TASK_W-1:0]    out_owner_task,
  output logic                          out_prio_write,
  output logic [pim_pkg::TASK_W-1:0]    out_prio_task,
  output logic [pim_pkg::PRIO_W-1:0]    out_prio_value,
  output logic                          out_woken_valid,
  output logic [pim_pkg::TASK_W-1:0]    out_woken_task,
  output logic                          out_switch_request
);

  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int AW = $clog2(MAX_TASKS);
  localparam int TW = pim_pkg::TASK_W;
  localparam int PW = pim_pkg::PRIO_W;
  localparam int EW = TW + PW;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_SHIFT = 3'b100
  } state_t;

  typedef struct packed {
    pim_pkg::status_t status;
    logic             owner_valid;
    logic [TW-1:0]    owner_task;
    logic             prio_write;
    logic [TW-1:0]    prio_task;
    logic [PW-1:0]    prio_value;
    logic             woken_valid;
    logic [TW-1:0]    woken_task;
    logic             switch_request;
  } result_t;

  state_t        state_r, state_nxt;
  logic          locked_r, locked_nxt;
  logic [TW-1:0] holder_r, holder_nxt;
  logic [PW-1:0] base_r, base_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] min_r, min_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pend_idx_r, pend_idx_nxt;
  logic [TW-1:0] best_id_r, best_id_nxt;
  logic [PW-1:0] best_pr_r, best_pr_nxt;
  logic [AW-1:0] best_idx_r, best_idx_nxt;
  logic [PW-1:0] rest_r, rest_nxt;
  logic          out_valid_r, out_valid_nxt;
  result_t       res_r, res_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] rd_data;

  logic          accept;
  logic          is_holder;
  logic          full;
  logic [PW-1:0] queued_min;
  logic [TW-1:0] e_id;
  logic [PW-1:0] e_pr;
  logic [TW-1:0] cand_id;
  logic [PW-1:0] cand_pr;
  logic [AW-1:0] cand_idx;
  logic [PW-1:0] cand_rest;

  pim_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_TASKS)
  ) u_queue (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign accept     = start && (state_r == ST_IDLE);
  assign is_holder  = locked_r && (holder_r == in_task_id);
  assign full       = (count_r == CW'(MAX_TASKS));
  assign queued_min = (count_r == '0) ? in_task_priority :
                      ((in_task_priority < min_r) ? in_task_priority : min_r);

  assign e_id = rd_data[EW-1:PW];
  assign e_pr = rd_data[PW-1:0];

  // Running minimum over the scanned waiters; the earliest wins ties.
  // rest tracks the minimum over all scanned entries except the winner.
  always_comb begin
    cand_id   = best_id_r;
    cand_pr   = best_pr_r;
    cand_idx  = best_idx_r;
    cand_rest = rest_r;
    if (pend_idx_r == '0) begin
      cand_id   = e_id;
      cand_pr   = e_pr;
      cand_idx  = '0;
      cand_rest = pim_pkg::PRIO_MAX;
    end else if (e_pr < best_pr_r) begin
      cand_id   = e_id;
      cand_pr   = e_pr;
      cand_idx  = pend_idx_r;
      cand_rest = (best_pr_r < rest_r) ? best_pr_r : rest_r;
    end else begin
      cand_rest = (e_pr < rest_r) ? e_pr : rest_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    locked_nxt    = locked_r;
    holder_nxt    = holder_r;
    base_nxt      = base_r;
    count_nxt     = count_r;
    min_nxt       = min_r;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    best_id_nxt   = best_id_r;
    best_pr_nxt   = best_pr_r;
    best_idx_nxt  = best_idx_r;
    rest_nxt      = rest_r;
    out_valid_nxt = 1'b0;
    res_nxt       = res_r;
    wr_en         = 1'b0;
    wr_addr       = count_r[AW-1:0];
    wr_data       = {in_task_id, in_task_priority};
    rd_addr       = idx_r[AW-1:0];

    // Issue one queue read per cycle while scanning or shifting.
    if ((state_r != ST_IDLE) && (idx_r < count_r)) begin
      pend_nxt     = 1'b1;
      pend_idx_nxt = idx_r[AW-1:0];
      idx_nxt      = idx_r + CW'(1);
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          res_nxt       = '0;
          if (in_operation == pim_pkg::OP_LOCK) begin
            if (!locked_r) begin
              locked_nxt     = 1'b1;
              holder_nxt     = in_task_id;
              base_nxt       = in_task_priority;
              res_nxt.status = pim_pkg::STAT_ACQUIRED;
            end else if (full) begin
              res_nxt.status = pim_pkg::STAT_FULL;
            end else begin
              wr_en                  = 1'b1;
              count_nxt              = count_r + CW'(1);
              min_nxt                = queued_min;
              res_nxt.status         = pim_pkg::STAT_QUEUED;
              res_nxt.switch_request = 1'b1;
              if (queued_min < base_r) begin
                res_nxt.prio_write = 1'b1;
                res_nxt.prio_task  = holder_r;
                res_nxt.prio_value = queued_min;
              end
            end
            res_nxt.owner_valid = 1'b1;
            res_nxt.owner_task  = locked_r ? holder_r : in_task_id;
          end else if (!is_holder) begin
            res_nxt.status      = pim_pkg::STAT_NOT_OWNER;
            res_nxt.owner_valid = locked_r;
            res_nxt.owner_task  = locked_r ? holder_r : '0;
          end else if (count_r == '0) begin
            locked_nxt         = 1'b0;
            holder_nxt         = '0;
            res_nxt.status     = pim_pkg::STAT_RELEASED;
            res_nxt.prio_write = 1'b1;
            res_nxt.prio_task  = holder_r;
            res_nxt.prio_value = base_r;
          end else begin
            // Hold the result until the queue has been reordered.
            out_valid_nxt = 1'b0;
            idx_nxt       = '0;
            state_nxt     = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (pend_r) begin
          best_id_nxt  = cand_id;
          best_pr_nxt  = cand_pr;
          best_idx_nxt = cand_idx;
          rest_nxt     = cand_rest;
          if (CW'(pend_idx_r) == count_r - CW'(1)) begin
            idx_nxt   = CW'(cand_idx) + CW'(1);
            state_nxt = ST_SHIFT;
          end
        end
      end

      ST_SHIFT: begin
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = pend_idx_r - AW'(1);
          wr_data = rd_data;
        end else if (idx_r >= count_r) begin
          state_nxt              = ST_IDLE;
          holder_nxt             = best_id_r;
          base_nxt               = best_pr_r;
          count_nxt              = count_r - CW'(1);
          min_nxt                = rest_r;
          out_valid_nxt          = 1'b1;
          res_nxt.status         = pim_pkg::STAT_HANDOFF;
          res_nxt.owner_valid    = 1'b1;
          res_nxt.owner_task     = best_id_r;
          res_nxt.prio_write     = 1'b1;
          res_nxt.prio_task      = holder_r;
          res_nxt.prio_value     = base_r;
          res_nxt.woken_valid    = 1'b1;
          res_nxt.woken_task     = best_id_r;
          res_nxt.switch_request = 1'b1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      locked_r    <= 1'b0;
      holder_r    <= '0;
      base_r      <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      locked_r    <= locked_nxt;
      holder_r    <= holder_nxt;
      base_r      <= base_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    min_r      <= min_nxt;
    idx_r      <= idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    best_id_r  <= best_id_nxt;
    best_pr_r  <= best_pr_nxt;
    best_idx_r <= best_idx_nxt;
    rest_r     <= rest_nxt;
    res_r      <= res_nxt;
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = res_r.status;
  assign out_owner_valid    = res_r.owner_valid;
  assign out_owner_task     = res_r.owner_task;
  assign out_prio_write     = res_r.prio_write;
  assign out_prio_task      = res_r.prio_task;
  assign out_prio_value     = res_r.prio_value;
  assign out_woken_valid    = res_r.woken_valid;
  assign out_woken_task     = res_r.woken_task;
  assign out_switch_request = res_r.switch_request;

endmodule

// ----- hw/rtl/pim_checker.sv -----
module pim_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic [pim_pkg::STATUS_W-1:0] out_status,
  input logic                         out_owner_valid,
  input logic [pim_pkg::TASK_W-1:0]   out_owner_task,
  input logic                         out_prio_write,
  input logic                         out_woken_valid,
  input logic [pim_pkg::TASK_W-1:0]   out_woken_task,
  input logic                         out_switch_request
);

  // A taken transaction either answers at once or starts the handoff.
  a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("transaction taken without result or busy");

  a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_handoff_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == pim_pkg::STAT_HANDOFF)) |->
      (out_woken_valid && out_switch_request && out_owner_valid && out_prio_write &&
       (out_woken_task == out_owner_task)))
    else $error("handoff result inconsistent");

  a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_status == pim_pkg::STAT_NOT_OWNER) ||
                   (out_status == pim_pkg::STAT_FULL))) |->
      (!out_prio_write && !out_switch_request && !out_woken_valid))
    else $error("rejected transaction had side effects");

  a_release_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == pim_pkg::STAT_RELEASED)) |->
      (!out_owner_valid && out_prio_write && !out_switch_request))
    else $error("release result inconsistent");

endmodule

bind priority_inheritance_mutex pim_checker u_pim_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_status         (out_status),
  .out_owner_valid    (out_owner_valid),
  .out_owner_task     (out_owner_task),
  .out_prio_write     (out_prio_write),
  .out_woken_valid    (out_woken_valid),
  .out_woken_task     (out_woken_task),
  .out_switch_request (out_switch_request)
);

// ----- bench/testbench.sv -----
module testbench;
  import pim_pkg::*;

  typedef struct packed {
    status_t             status;
    logic                owner_valid;
    logic [TASK_W-1:0]   owner_task;
    logic                prio_write;
    logic [TASK_W-1:0]   prio_task;
    logic [PRIO_W-1:0]   prio_value;
    logic                woken_valid;
    logic [TASK_W-1:0]   woken_task;
    logic                switch_request;
  } mutex_result_t;

  class mutex_scoreboard;
    bit                held;
    logic [TASK_W-1:0] owner;
    logic [PRIO_W-1:0] owner_base;
    int                waiter_count;
    logic [TASK_W-1:0] waiter_id[MAX_TASKS];
    logic [PRIO_W-1:0] waiter_prio[MAX_TASKS];
    mutex_result_t     expected_results[$];
    int                errors;

    function new();
      held = 0;
      owner = '0;
      owner_base = '0;
      waiter_count = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Advance the mutex state by one accepted transaction and queue its result.
    function void note_request(op_t op, logic [TASK_W-1:0] id, logic [PRIO_W-1:0] prio);
      mutex_result_t r;
      logic [PRIO_W-1:0] best;
      int pick;
      int i;
      r = '0;
      if (op == OP_LOCK) begin
        if (!held) begin
          held = 1;
          owner = id;
          owner_base = prio;
          r.status = STAT_ACQUIRED;
        end else if (waiter_count >= MAX_TASKS) begin
          r.status = STAT_FULL;
        end else begin
          waiter_id[waiter_count] = id;
          waiter_prio[waiter_count] = prio;
          waiter_count++;
          best = PRIO_MAX;
          for (i = 0; i < waiter_count; i++)
            if (waiter_prio[i] < best) best = waiter_prio[i];
          // inherit only when strictly more urgent than the base
          if (best < owner_base) begin
            r.prio_write = 1'b1;
            r.prio_task = owner;
            r.prio_value = best;
          end
          r.switch_request = 1'b1;
          r.status = STAT_QUEUED;
        end
      end else if (!held || owner != id) begin
        r.status = STAT_NOT_OWNER;
      end else begin
        r.prio_write = 1'b1;
        r.prio_task = owner;
        r.prio_value = owner_base;
        if (waiter_count > 0) begin
          // strict compare keeps the earliest waiter on a tie
          pick = 0;
          for (i = 1; i < waiter_count; i++)
            if (waiter_prio[i] < waiter_prio[pick]) pick = i;
          owner = waiter_id[pick];
          owner_base = waiter_prio[pick];
          for (i = pick; i + 1 < waiter_count; i++) begin
            waiter_id[i] = waiter_id[i+1];
            waiter_prio[i] = waiter_prio[i+1];
          end
          waiter_count--;
          r.woken_valid = 1'b1;
          r.woken_task = owner;
          r.switch_request = 1'b1;
          r.status = STAT_HANDOFF;
        end else begin
          held = 0;
          owner = '0;
          r.status = STAT_RELEASED;
        end
      end
      r.owner_valid = held;
      r.owner_task = held ? owner : '0;
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(mutex_result_t got);
      mutex_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d owner %0d",
                 $time, got.status, got.owner_task);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("owner_valid", want.owner_valid, got.owner_valid);
      compare_field("owner_task", want.owner_task, got.owner_task);
      compare_field("prio_write", want.prio_write, got.prio_write);
      compare_field("prio_task", want.prio_task, got.prio_task);
      compare_field("prio_value", want.prio_value, got.prio_value);
      compare_field("woken_valid", want.woken_valid, got.woken_valid);
      compare_field("woken_task", want.woken_task, got.woken_task);
      compare_field("switch_request", want.switch_request, got.switch_request);
    endfunction
  endclass

  localparam int ITEM_TARGET = 1950;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_operation = 1'b0;
  logic [TASK_W-1:0]    in_task_id = '0;
  logic [PRIO_W-1:0]    in_task_priority = '0;
  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic                 out_owner_valid;
  logic [TASK_W-1:0]    out_owner_task;
  logic                 out_prio_write;
  logic [TASK_W-1:0]    out_prio_task;
  logic [PRIO_W-1:0]    out_prio_value;
  logic                 out_woken_valid;
  logic [TASK_W-1:0]    out_woken_task;
  logic                 out_switch_request;

  mutex_scoreboard sb;
  int  items_sent = 0;
  bit  quiet = 0;

  priority_inheritance_mutex u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_operation       (in_operation),
    .in_task_id         (in_task_id),
    .in_task_priority   (in_task_priority),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_owner_valid    (out_owner_valid),
    .out_owner_task     (out_owner_task),
    .out_prio_write     (out_prio_write),
    .out_prio_task      (out_prio_task),
    .out_prio_value     (out_prio_value),
    .out_woken_valid    (out_woken_valid),
    .out_woken_task     (out_woken_task),
    .out_switch_request (out_switch_request)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result('{status: status_t'(out_status), owner_valid: out_owner_valid,
                        owner_task: out_owner_task, prio_write: out_prio_write,
                        prio_task: out_prio_task, prio_value: out_prio_value,
                        woken_valid: out_woken_valid, woken_task: out_woken_task,
                        switch_request: out_switch_request});
    end
  end

  function automatic logic [PRIO_W-1:0] rand_prio();
    case ($urandom_range(0, 3))
      0: rand_prio = $urandom_range(0, 1) ? PRIO_MAX : '0;
      1: rand_prio = PRIO_W'($urandom_range(0, 7));   // crowd values to force ties
      default: rand_prio = PRIO_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [TASK_W-1:0] rand_task();
    return TASK_W'($urandom_range(0, 15));
  endfunction

  // Hold start until the transaction is taken, then note it.
  task automatic send_item(op_t op, logic [TASK_W-1:0] id, logic [PRIO_W-1:0] prio);
    start <= 1'b1;
    in_operation <= op;
    in_task_id <= id;
    in_task_priority <= prio;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(op, id, prio);
    items_sent++;
  endtask

  task automatic maybe_idle();
    if (!quiet && $urandom_range(0, 99) < 25) begin
      start <= 1'b0;
      in_operation <= 1'($urandom_range(0, 1));
      in_task_id <= rand_task();
      in_task_priority <= rand_prio();
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Fill the wait queue, overflow it, then unlock until free.
  task automatic fill_and_empty();
    int extra;
    extra = $urandom_range(1, 3);
    if (!sb.held) begin
      send_item(OP_LOCK, rand_task(), rand_prio());
      maybe_idle();
    end
    while (sb.waiter_count < MAX_TASKS) begin
      send_item(OP_LOCK, rand_task(), rand_prio());
      maybe_idle();
    end
    repeat (extra) begin
      send_item(OP_LOCK, rand_task(), rand_prio());
      maybe_idle();
    end
    while (sb.held) begin
      send_item(OP_UNLOCK, sb.owner, rand_prio());
      maybe_idle();
    end
  endtask

  initial begin
    #5_000_000;
    $display("priority_inheritance_mutex regression: fail");
    $finish;
  end

  initial begin
    int iter;
    int roll;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: rejects, inheritance, ties, self-relock, handoffs, release
    send_item(OP_UNLOCK, 4'd0, 8'd0);
    send_item(OP_LOCK, 4'd15, 8'd255);
    send_item(OP_UNLOCK, 4'd3, 8'd0);
    maybe_idle();
    send_item(OP_LOCK, 4'd0, 8'd0);
    send_item(OP_LOCK, 4'd7, 8'd0);
    send_item(OP_LOCK, 4'd15, 8'd128);
    send_item(OP_LOCK, 4'd9, 8'd255);
    send_item(OP_UNLOCK, 4'd15, 8'd255);
    send_item(OP_UNLOCK, 4'd0, 8'd0);
    maybe_idle();
    send_item(OP_UNLOCK, 4'd7, 8'd0);
    send_item(OP_LOCK, 4'd4, 8'd200);
    send_item(OP_UNLOCK, 4'd9, 8'd255);
    send_item(OP_UNLOCK, 4'd15, 8'd128);
    send_item(OP_UNLOCK, 4'd4, 8'd200);
    send_item(OP_UNLOCK, 4'd9, 8'd255);
    send_item(OP_UNLOCK, 4'd9, 8'd255);
    send_item(OP_LOCK, 4'd1, 8'd0);
    send_item(OP_LOCK, 4'd2, 8'd255);
    send_item(OP_LOCK, 4'd14, 8'd0);
    send_item(OP_UNLOCK, 4'd1, 8'd0);
    send_item(OP_UNLOCK, 4'd2, 8'd255);
    send_item(OP_UNLOCK, 4'd14, 8'd0);
    drain();

    iter = 0;
    while (items_sent < ITEM_TARGET) begin
      quiet = (iter >= 400 && iter < 700);
      if (iter % 120 == 0) fill_and_empty();
      if (iter == 500) drain();
      roll = $urandom_range(0, 99);
      if (!sb.held) begin
        if (roll < 80) send_item(OP_LOCK, rand_task(), rand_prio());
        else send_item(OP_UNLOCK, rand_task(), rand_prio());
      end else if (roll < 38) begin
        send_item(OP_UNLOCK, sb.owner, rand_prio());
      end else if (roll < 83) begin
        send_item(OP_LOCK, rand_task(), rand_prio());
      end else if (roll < 88) begin
        send_item(OP_LOCK, sb.owner, rand_prio());
      end else begin
        send_item(OP_UNLOCK, rand_task(), rand_prio());
      end
      maybe_idle();
      iter++;
    end

    drain();
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("priority_inheritance_mutex regression: pass");
    end else begin
      $display("priority_inheritance_mutex regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/pim_pkg.sv
hw/rtl/pim_ram.sv
hw/rtl/priority_inheritance_mutex.sv
hw/rtl/pim_checker.sv
bench/testbench.sv
